// ===== src/aimc_pkg.sv =====
// Shared types, codes and defaults for the array intersection match table.
package aimc_pkg;

    localparam int VALUE_BITS        = 32;
    localparam int STATUS_BITS       = 3;
    localparam int DEF_TABLE_DEPTH   = 32;
    localparam int DEF_VALUE_WIDTH   = 32;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_PROBE = 2'd2;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_MATCH   = 3'd0,
        ST_NOMATCH = 3'd1,
        ST_LOADED  = 3'd2,
        ST_FULL    = 3'd3,
        ST_CLEARED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic clear;
        logic load;
        logic probe;
        logic emit;
        logic nomatch;
    } t_ctl_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       hit_any;
        logic       last_hit;
        logic       out_free;
    } t_ctl_sts;

endpackage

// ===== src/array_intersection_match_clear.sv =====
// Top level of the array intersection match table: controller plus datapath.
//
// Input channel (i_in_valid / o_in_stall) carries a mode and a signed value:
// clear empties the table, load appends the value at the fill position (or
// reports the table full and drops it), probe compares the value against all
// valid entries in parallel. Entries freed by a probe stay unused until clear.
// Output channel (o_out_valid / i_out_stall) carries one result beat per
// clear or load, one per matching entry of a probe in entry order (each match
// invalidates its entry), or one no-match beat. o_last marks the final beat of
// an input beat. The undefined mode is taken and gives no result.
// A clear, load or no-match result is loaded into the output register in the
// execute step after the input beat is taken; a probe with matches latches its
// hits in the execute step and loads its first match beat in the emit step,
// then emits one match per cycle while the output is free, from the latched
// match vector. The next input beat is taken while the last result still waits.
// Reset (synchronous, active low) clears every valid bit, the fill count, the
// match vector and output valid bit; entry and output values are not cleared.
// A stalled result holds its beat; the controller waits, and the input side
// stalls, until the output register frees up.
module array_intersection_match_clear #(
    parameter int TABLE_DEPTH = aimc_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = aimc_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [1:0]                              i_mode,
    input  logic signed [aimc_pkg::VALUE_BITS-1:0]  i_value,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [aimc_pkg::VALUE_BITS-1:0]  o_out_value,
    output logic [aimc_pkg::STATUS_BITS-1:0]        o_status,
    output logic                                    o_last
);

    aimc_pkg::t_ctl_cmd w_cmd;
    aimc_pkg::t_ctl_sts w_sts;

    aimc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    aimc_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_value (o_out_value),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

// ===== src/aimc_datapath.sv =====
// Datapath: entry table with valid bits, parallel compare, match vector and result register.
module aimc_datapath #(
    parameter int TABLE_DEPTH = aimc_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = aimc_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic [1:0]                              i_mode,
    input  logic signed [aimc_pkg::VALUE_BITS-1:0]  i_value,
    input  aimc_pkg::t_ctl_cmd                      i_cmd,
    output aimc_pkg::t_ctl_sts                      o_sts,
    input  logic                                    i_out_stall,
    output logic                                    o_out_valid,
    output logic signed [aimc_pkg::VALUE_BITS-1:0]  o_out_value,
    output logic [aimc_pkg::STATUS_BITS-1:0]        o_status,
    output logic                                    o_last
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [1:0]                         r_mode;
    logic [aimc_pkg::VALUE_BITS-1:0]    r_value;
    logic [VALUE_WIDTH-1:0]             r_entry_value [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]             r_entry_valid;
    logic [CNT_W-1:0]                   r_fill_count;
    logic [TABLE_DEPTH-1:0]             r_match;
    logic                               r_out_valid;
    logic [aimc_pkg::VALUE_BITS-1:0]    r_out_value;
    aimc_pkg::t_status                  r_out_status;
    logic                               r_out_last;

    logic [VALUE_WIDTH-1:0]             w_key;
    logic [TABLE_DEPTH-1:0]             w_hit;
    logic [TABLE_DEPTH-1:0]             w_first;
    logic [TABLE_DEPTH-1:0]             w_rest;
    logic [IDX_W-1:0]                   w_fill_idx;
    logic                               w_full;
    logic                               w_out_free;
    logic                               w_out_load;
    logic [aimc_pkg::VALUE_BITS-1:0]    n_out_value;
    aimc_pkg::t_status                  n_out_status;
    logic                               n_out_last;

    assign w_key      = VALUE_WIDTH'(r_value);
    assign w_full     = (r_fill_count == CNT_W'(TABLE_DEPTH));
    assign w_fill_idx = r_fill_count[IDX_W-1:0];
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_hit[i] = r_entry_valid[i] && (r_entry_value[i] == w_key);
        end
    end

    // Isolate the lowest pending match; entry order is index order.
    assign w_first = r_match & (~r_match + TABLE_DEPTH'(1));
    assign w_rest  = r_match & ~w_first;

    assign w_out_load = i_cmd.clear || i_cmd.load || i_cmd.nomatch || i_cmd.emit;

    always_comb begin
        n_out_value  = '0;
        n_out_status = aimc_pkg::ST_CLEARED;
        n_out_last   = 1'b1;
        if (i_cmd.load) begin
            n_out_status = w_full ? aimc_pkg::ST_FULL : aimc_pkg::ST_LOADED;
        end else if (i_cmd.nomatch) begin
            n_out_status = aimc_pkg::ST_NOMATCH;
        end else if (i_cmd.emit) begin
            n_out_value  = r_value;
            n_out_status = aimc_pkg::ST_MATCH;
            n_out_last   = ~|w_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_fill_count  <= '0;
            r_match       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_entry_valid <= '0;
                r_fill_count  <= '0;
            end
            if (i_cmd.load && !w_full) begin
                r_entry_valid[w_fill_idx] <= 1'b1;
                r_fill_count              <= r_fill_count + CNT_W'(1);
            end
            // Matched entries drop out at once; the results follow from r_match.
            if (i_cmd.probe) begin
                r_entry_valid <= r_entry_valid & ~w_hit;
                r_match       <= w_hit;
            end
            if (i_cmd.emit) begin
                r_match <= w_rest;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_value <= i_value;
        end
        if (i_cmd.load && !w_full) begin
            r_entry_value[w_fill_idx] <= w_key;
        end
        if (w_out_load) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
            r_out_last   <= n_out_last;
        end
    end

    assign o_sts.mode     = r_mode;
    assign o_sts.hit_any  = |w_hit;
    assign o_sts.last_hit = ~|w_rest;
    assign o_sts.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_value = signed'(r_out_value);
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

endmodule

// ===== src/aimc_ctrl.sv =====
// Controller: sequences accept, execute and match emission for each input beat.
module aimc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  aimc_pkg::t_ctl_sts  i_sts,
    output aimc_pkg::t_ctl_cmd  o_cmd
);

    aimc_pkg::t_state r_state;
    aimc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aimc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            aimc_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = aimc_pkg::S_EXEC;
                end
            end
            aimc_pkg::S_EXEC: begin
                unique case (i_sts.mode)
                    aimc_pkg::MODE_CLEAR: begin
                        if (i_sts.out_free) begin
                            o_cmd.clear = 1'b1;
                            n_state     = aimc_pkg::S_IDLE;
                        end
                    end
                    aimc_pkg::MODE_LOAD: begin
                        if (i_sts.out_free) begin
                            o_cmd.load = 1'b1;
                            n_state    = aimc_pkg::S_IDLE;
                        end
                    end
                    aimc_pkg::MODE_PROBE: begin
                        // Latch the hits now; emission waits on the output register.
                        if (i_sts.hit_any) begin
                            o_cmd.probe = 1'b1;
                            n_state     = aimc_pkg::S_EMIT;
                        end else if (i_sts.out_free) begin
                            o_cmd.nomatch = 1'b1;
                            n_state       = aimc_pkg::S_IDLE;
                        end
                    end
                    default: begin
                        // drop the undefined mode without a result
                        n_state = aimc_pkg::S_IDLE;
                    end
                endcase
            end
            aimc_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_hit) begin
                        n_state = aimc_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = aimc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the array intersection match table: random stall traffic on both sides.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = aimc_pkg::DEF_TABLE_DEPTH;
    localparam int ITEM_TARGET = 250;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 16;
    localparam int REPORT_MAX  = 10;
    localparam logic [1:0] MODE_UNDEF = 2'd3;

    typedef struct {
        logic [aimc_pkg::VALUE_BITS-1:0] value;
        aimc_pkg::t_status               status;
        logic                            last;
    } t_match_result;

    // Tracks the table contents and the result beats each accepted command must produce.
    class match_scoreboard;
        logic [aimc_pkg::VALUE_BITS-1:0] entry_val [DEPTH];
        bit                              entry_vld [DEPTH];
        int unsigned                     fill;
        t_match_result                   expected_q [$];
        int                              errors;

        function new();
            foreach (entry_vld[i]) begin
                entry_vld[i] = 1'b0;
                entry_val[i] = '0;
            end
            fill   = 0;
            errors = 0;
        endfunction

        function void push_result(logic [aimc_pkg::VALUE_BITS-1:0] value,
                                  aimc_pkg::t_status status, logic last);
            t_match_result r;
            r.value  = value;
            r.status = status;
            r.last   = last;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_beat(logic [1:0] mode, logic [aimc_pkg::VALUE_BITS-1:0] value);
            int hits;
            hits = 0;
            case (mode)
                aimc_pkg::MODE_CLEAR: begin
                    foreach (entry_vld[i]) entry_vld[i] = 1'b0;
                    fill = 0;
                    push_result('0, aimc_pkg::ST_CLEARED, 1'b1);
                end
                aimc_pkg::MODE_LOAD: begin
                    if (fill >= DEPTH) begin
                        push_result('0, aimc_pkg::ST_FULL, 1'b1);
                    end else begin
                        entry_val[fill] = value;
                        entry_vld[fill] = 1'b1;
                        fill++;
                        push_result('0, aimc_pkg::ST_LOADED, 1'b1);
                    end
                end
                aimc_pkg::MODE_PROBE: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (entry_vld[i] && entry_val[i] == value) begin
                            entry_vld[i] = 1'b0;
                            push_result(value, aimc_pkg::ST_MATCH, 1'b0);
                            hits++;
                        end
                    end
                    if (hits == 0)
                        push_result('0, aimc_pkg::ST_NOMATCH, 1'b1);
                    else
                        expected_q[expected_q.size()-1].last = 1'b1;
                end
                default: ;  // undefined mode: no state change, no beat
            endcase
        endfunction

        function void check_result(logic [aimc_pkg::VALUE_BITS-1:0] value,
                                   logic [aimc_pkg::STATUS_BITS-1:0] status,
                                   logic last);
            t_match_result exp_r;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: unexpected result beat: value %h status %0d last %0b",
                             $realtime, value, status, last);
                return;
            end
            exp_r = expected_q.pop_front();
            if (exp_r.value !== value || exp_r.status !== status || exp_r.last !== last) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display({"%0t: mismatch: expected value %h status %0d last %0b, ",
                              "got value %h status %0d last %0b"},
                             $realtime, exp_r.value, exp_r.status, exp_r.last,
                             value, status, last);
            end
        endfunction
    endclass

    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n = 1'b0;
    logic                                   i_in_valid = 1'b0;
    logic                                   o_in_stall;
    logic [1:0]                             i_mode = aimc_pkg::MODE_CLEAR;
    logic signed [aimc_pkg::VALUE_BITS-1:0] i_value = '0;
    logic                                   o_out_valid;
    logic                                   i_out_stall = 1'b0;
    logic signed [aimc_pkg::VALUE_BITS-1:0] o_out_value;
    logic [aimc_pkg::STATUS_BITS-1:0]       o_status;
    logic                                   o_last;

    match_scoreboard sb = new();
    int              tx_idle_pct = 7;
    int              rx_stall_pct = 71;
    int              sent_items = 0;
    int              cycles = 0;

    array_intersection_match_clear i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_value (o_out_value),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_value, o_status, o_last);
    end

    // Present one command beat, hold it until taken, then log it.
    task automatic send_beat(input logic [1:0] mode,
                             input logic [aimc_pkg::VALUE_BITS-1:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_value    <= value;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_beat(mode, value);
        if (mode != MODE_UNDEF) sent_items++;
    endtask

    function automatic logic [aimc_pkg::VALUE_BITS-1:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Usually clear, fill from a small value pool, then probe mostly pool values so matches are common.
    task automatic run_sequence();
        logic [aimc_pkg::VALUE_BITS-1:0] pool [8];
        int n_load;
        int n_probe;
        foreach (pool[k]) pool[k] = pick_value();
        if ($urandom_range(9) != 0) send_beat(aimc_pkg::MODE_CLEAR, $urandom);
        n_load = ($urandom_range(3) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 16);
        repeat (n_load) send_beat(aimc_pkg::MODE_LOAD, pool[$urandom_range(7)]);
        n_probe = $urandom_range(1, 12);
        repeat (n_probe) begin
            case ($urandom_range(9))
                0, 1:    send_beat(aimc_pkg::MODE_PROBE, $urandom);
                2:       send_beat(aimc_pkg::MODE_LOAD, pool[$urandom_range(7)]);
                default: send_beat(aimc_pkg::MODE_PROBE, pool[$urandom_range(7)]);
            endcase
        end
        repeat ($urandom_range(3)) send_beat(2'($urandom_range(3)), $urandom);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // probe on an empty table, extremes, repeated values, undefined mode
        send_beat(aimc_pkg::MODE_PROBE, 32'h0000_0000);
        send_beat(aimc_pkg::MODE_LOAD,  32'h8000_0000);
        send_beat(aimc_pkg::MODE_LOAD,  32'h7fff_ffff);
        send_beat(aimc_pkg::MODE_LOAD,  32'h0000_0000);
        send_beat(aimc_pkg::MODE_LOAD,  32'hffff_ffff);
        send_beat(aimc_pkg::MODE_LOAD,  32'd5);
        send_beat(aimc_pkg::MODE_LOAD,  32'd5);
        send_beat(aimc_pkg::MODE_LOAD,  32'd5);
        send_beat(MODE_UNDEF,           32'd5);
        send_beat(aimc_pkg::MODE_PROBE, 32'd5);
        send_beat(aimc_pkg::MODE_PROBE, 32'd5);
        send_beat(aimc_pkg::MODE_PROBE, 32'h8000_0000);
        send_beat(aimc_pkg::MODE_PROBE, 32'h7fff_ffff);
        send_beat(aimc_pkg::MODE_PROBE, 32'h0000_0000);
        send_beat(aimc_pkg::MODE_PROBE, 32'hffff_ffff);
        // freed slots are not reused: the new load lands past them
        send_beat(aimc_pkg::MODE_LOAD,  32'd5);
        send_beat(aimc_pkg::MODE_PROBE, 32'd5);
        send_beat(aimc_pkg::MODE_CLEAR, 32'h0000_0000);
        // stale values stay in the table but must not match after clear
        send_beat(aimc_pkg::MODE_PROBE, 32'h0000_0000);
        send_beat(aimc_pkg::MODE_LOAD,  32'd1);
        send_beat(aimc_pkg::MODE_PROBE, 32'd1);
        send_beat(aimc_pkg::MODE_CLEAR, 32'hffff_ffff);

        while (sent_items < ITEM_TARGET) begin
            if (sent_items >= 2 * ITEM_TARGET / 3) begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end else if (sent_items >= ITEM_TARGET / 3) begin
                tx_idle_pct  = 71;
                rx_stall_pct = 7;
            end
            run_sequence();
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== array_intersection_match_clear.f =====
src/aimc_pkg.sv
src/aimc_datapath.sv
src/aimc_ctrl.sv
src/array_intersection_match_clear.sv
bench/tb_top.sv
